### hdl/rsta_pkg.sv
// rsta_pkg: shared types and constants of the row softmax / tanh activation unit
// fixed-point exponent constants, register indexes and the controller state type
// no dependencies
package rsta_pkg;

	localparam int ACT_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int SUM_W      = 23;
	localparam int EXP_STEPS  = 12;
	localparam int DIV_STEPS  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SOFTMAX_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH   = 2'd1;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [16:0] ONE_Q16   = 17'd65536;
	localparam logic [15:0] ONE_Q15   = 16'd32768;
	localparam logic [15:0] MAX_Q15   = 16'd32767;
	localparam logic [CFG_DATA_W-1:0] ROW_LENGTH_RESET = 7'd64;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SC_RD,
		ST_SC_D,
		ST_EXP_T,
		ST_EXP_IT,
		ST_EXP_FIN,
		ST_EV_RD,
		ST_EV_N,
		ST_DIV,
		ST_OUT
	} state_t;

	// round(65536 * 2^(-2^-(k+1))) for fraction bit k+1
	function automatic logic [15:0] pow2_neg_frac(input logic [3:0] k);
		logic [15:0] c;
		unique case (k)
			4'd0:    c = 16'd46341;
			4'd1:    c = 16'd55109;
			4'd2:    c = 16'd60097;
			4'd3:    c = 16'd62757;
			4'd4:    c = 16'd64132;
			4'd5:    c = 16'd64830;
			4'd6:    c = 16'd65182;
			4'd7:    c = 16'd65359;
			4'd8:    c = 16'd65447;
			4'd9:    c = 16'd65492;
			4'd10:   c = 16'd65514;
			4'd11:   c = 16'd65525;
			default: c = 16'd0;
		endcase
		return c;
	endfunction

endpackage

### hdl/rsta_ifs.sv
// rsta_ifs: valid/ready channel interfaces of the activation unit
// score input, activation result and configuration write channels
// depends on rsta_pkg
interface rsta_score_if #(parameter int SCORE_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [SCORE_BITS-1:0] score;
	modport source (output valid, output score, input ready);
	modport sink (input valid, input score, output ready);
endinterface

interface rsta_act_if;
	import rsta_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [ACT_W-1:0] activation;
	logic                    row_end;
	modport source (output valid, output activation, output row_end, input ready);
	modport sink (input valid, input activation, input row_end, output ready);
endinterface

interface rsta_cfg_if;
	import rsta_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output idx, output data, input ready);
	modport sink (input valid, input idx, input data, output ready);
endinterface

### hdl/row_softmax_tanh_activation.sv
// tanh mode: a score beat is taken only once the last result is loaded for output
// softmax row of L scores: scores are loaded one per cycle; the exponent pass then
// handles each entry in turn, then each result is divided out before the next starts
// (shared exp unit, one 17x16 multiply per cycle, bit-serial divider of 16 steps)
// reset clears control, mode goes to tanh and row length to 64; the score and exp
// memories are not cleared, entries are always written before they are read
module row_softmax_tanh_activation
	import rsta_pkg::*;
#(
	parameter int MAX_ROW    = 64,
	parameter int SCORE_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	rsta_score_if.sink score_ch,
	rsta_act_if.source result_ch,
	rsta_cfg_if.sink   cfg
);

	localparam int IW    = $clog2(MAX_ROW);
	localparam int CW    = $clog2(MAX_ROW + 1);
	localparam int DW    = SCORE_BITS + 1;
	localparam int PW    = DW + 18;
	localparam int TW    = (DW + 1 > 13) ? DW + 1 : 13;
	localparam int REM_W = 24;
	localparam int NUM_W = 31;

	localparam logic signed [SCORE_BITS-1:0] MOST_NEG = {1'b1, {(SCORE_BITS-1){1'b0}}};

	state_t state_q, state_d;

	logic                         softmax_mode_q;
	logic [CFG_DATA_W-1:0]        row_length_q;
	logic signed [SCORE_BITS-1:0] running_max_q;
	logic [CW-1:0]                fill_q, idx_q, count_q;

	logic [SCORE_BITS-1:0] score_mem [MAX_ROW];
	logic [ACT_W-1:0]      exp_mem [MAX_ROW];
	logic [SCORE_BITS-1:0] score_rd_q;
	logic [ACT_W-1:0]      exp_rd_q;

	logic [DW-1:0]    d_q;
	logic [11:0]      tf_q;
	logic [4:0]       n_q;
	logic             zero_q;
	logic [16:0]      p_q;
	logic [3:0]       k_q;
	logic [SUM_W-1:0] sum_q;
	logic             tanh_q, neg_q;

	logic [REM_W-1:0] rem_q, div_d_q;
	logic [15:0]      nlo_q, quo_q;
	logic [3:0]       bit_q;

	logic                    out_valid_q, row_end_q;
	logic signed [ACT_W-1:0] act_q;

	// control decoded from state
	logic in_ready, accept, score_we, exp_we, out_load, last_entry;

	// input side
	logic signed [DW-1:0]         xs;
	logic [DW-1:0]                mag;
	logic signed [SCORE_BITS-1:0] x;
	logic [CW-1:0]                len_c, fill_next;
	logic                         row_done;

	// datapath
	logic [PW-1:0]    t_prod;
	logic [TW-1:0]    t_c, t_sh;
	logic [33:0]      p_prod;
	logic [17:0]      p_rnd;
	logic [17:0]      e_shift;
	logic [ACT_W-1:0] e_c;
	logic [16:0]      den_c;
	logic [NUM_W-1:0] num_tanh, num_soft;
	logic [REM_W:0]   r2;
	logic             ge;
	logic [15:0]      sat_c;
	logic [DW-1:0]    diff_c;

	assign x         = score_ch.score;
	assign xs        = {x[SCORE_BITS-1], x};
	assign mag       = xs[DW-1] ? DW'(-xs) : DW'(xs);
	assign fill_next = fill_q + CW'(1);
	assign row_done  = fill_next >= len_c;
	assign last_entry = (idx_q + CW'(1)) == count_q;

	always_comb begin
		if (row_length_q == '0) begin
			len_c = CW'(1);
		end else if (row_length_q > CFG_DATA_W'(MAX_ROW)) begin
			len_c = CW'(MAX_ROW);
		end else begin
			len_c = CW'(row_length_q);
		end
	end

	// exp(-d): t = d*log2(e), then one fraction bit per cycle, then a final shift
	assign t_prod  = PW'(d_q) * PW'(LOG2E_Q16) + PW'(32768);
	assign t_c     = TW'(t_prod >> 16);
	assign t_sh    = t_c >> 12;
	assign p_prod  = 34'(p_q) * 34'(pow2_neg_frac(k_q)) + 34'(32768);
	assign p_rnd   = 18'({1'b0, p_q}) + (18'd1 << n_q);
	assign e_shift = p_rnd >> (n_q + 5'd1);
	assign e_c     = zero_q ? '0 : ACT_W'(e_shift);

	assign den_c    = 17'(ONE_Q15) + 17'(e_c);
	assign num_tanh = {NUM_W'(ONE_Q15 - e_c) << 15} + NUM_W'(den_c >> 1);
	assign num_soft = {NUM_W'(exp_rd_q) << 15} + NUM_W'(sum_q >> 1);
	assign diff_c   = DW'({running_max_q[SCORE_BITS-1], running_max_q})
		- DW'({score_rd_q[SCORE_BITS-1], score_rd_q});

	assign r2    = {rem_q, nlo_q[15]};
	assign ge    = r2 >= {1'b0, div_d_q};
	assign sat_c = (quo_q > MAX_Q15) ? MAX_Q15 : quo_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!softmax_mode_q) begin
						state_d = ST_EXP_T;
					end else if (row_done) begin
						state_d = ST_SC_RD;
					end
				end
			end
			ST_SC_RD:  state_d = ST_SC_D;
			ST_SC_D:   state_d = ST_EXP_T;
			ST_EXP_T:  state_d = ST_EXP_IT;
			ST_EXP_IT: begin
				if (k_q == 4'(EXP_STEPS - 1)) begin
					state_d = ST_EXP_FIN;
				end
			end
			ST_EXP_FIN: begin
				if (tanh_q) begin
					state_d = ST_DIV;
				end else if (last_entry) begin
					state_d = ST_EV_RD;
				end else begin
					state_d = ST_SC_RD;
				end
			end
			ST_EV_RD: state_d = ST_EV_N;
			ST_EV_N:  state_d = ST_DIV;
			ST_DIV: begin
				if (bit_q == 4'(DIV_STEPS - 1)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = (tanh_q || last_entry) ? ST_IDLE : ST_EV_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = state_q == ST_IDLE;
		accept   = in_ready && score_ch.valid;
		score_we = accept && softmax_mode_q;
		exp_we   = (state_q == ST_EXP_FIN) && !tanh_q;
		out_load = (state_q == ST_OUT) && (!out_valid_q || result_ch.ready);
	end

	assign score_ch.ready = in_ready;
	assign cfg.ready      = 1'b1;
	assign result_ch.valid      = out_valid_q;
	assign result_ch.activation = act_q;
	assign result_ch.row_end    = row_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			softmax_mode_q <= 1'b0;
			row_length_q   <= ROW_LENGTH_RESET;
			running_max_q  <= MOST_NEG;
			fill_q         <= '0;
			idx_q          <= '0;
			count_q        <= '0;
			sum_q          <= '0;
			tanh_q         <= 1'b0;
			k_q            <= '0;
			bit_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				if (cfg.idx == REG_SOFTMAX_MODE) begin
					softmax_mode_q <= cfg.data[0];
				end else if (cfg.idx == REG_ROW_LENGTH) begin
					row_length_q <= cfg.data;
				end
			end
			if (accept) begin
				tanh_q <= !softmax_mode_q;
			end
			if (score_we) begin
				if (x > running_max_q) begin
					running_max_q <= x;
				end
				fill_q <= fill_next;
				if (row_done) begin
					count_q <= fill_next;
					idx_q   <= '0;
					sum_q   <= '0;
				end
			end
			if (state_q == ST_EXP_T) begin
				k_q <= '0;
			end else if (state_q == ST_EXP_IT) begin
				k_q <= k_q + 4'd1;
			end
			if (exp_we) begin
				sum_q <= sum_q + SUM_W'(e_c);
				idx_q <= last_entry ? '0 : idx_q + CW'(1);
			end
			if (state_q == ST_EV_N || (state_q == ST_EXP_FIN && tanh_q)) begin
				bit_q <= '0;
			end else if (state_q == ST_DIV) begin
				bit_q <= bit_q + 4'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (!tanh_q) begin
					if (last_entry) begin
						fill_q        <= '0;
						running_max_q <= MOST_NEG;
						idx_q         <= '0;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			d_q   <= {mag[DW-2:0], 1'b0};
			neg_q <= x[SCORE_BITS-1];
		end
		if (state_q == ST_SC_D) begin
			d_q   <= diff_c;
			neg_q <= 1'b0;
		end
		if (state_q == ST_EXP_T) begin
			tf_q   <= t_c[11:0];
			zero_q <= t_sh > TW'(16);
			n_q    <= 5'(t_sh);
			p_q    <= ONE_Q16;
		end
		if (state_q == ST_EXP_IT) begin
			tf_q <= {tf_q[10:0], 1'b0};
			if (tf_q[11]) begin
				p_q <= 17'(p_prod >> 16);
			end
		end
		if (state_q == ST_EXP_FIN && tanh_q) begin
			rem_q   <= REM_W'(num_tanh >> 16);
			nlo_q   <= num_tanh[15:0];
			div_d_q <= REM_W'(den_c);
		end
		if (state_q == ST_EV_N) begin
			rem_q   <= REM_W'(num_soft >> 16);
			nlo_q   <= num_soft[15:0];
			div_d_q <= REM_W'(sum_q);
		end
		if (state_q == ST_DIV) begin
			rem_q <= ge ? REM_W'(r2 - {1'b0, div_d_q}) : REM_W'(r2);
			nlo_q <= {nlo_q[14:0], 1'b0};
			quo_q <= {quo_q[14:0], ge};
		end
		if (out_load) begin
			act_q     <= neg_q ? -$signed(sat_c) : $signed(sat_c);
			row_end_q <= tanh_q || last_entry;
		end
	end

	// score and exponent memories
	always_ff @(posedge clk) begin
		if (score_we) begin
			score_mem[fill_q[IW-1:0]] <= x;
		end
		score_rd_q <= score_mem[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (exp_we) begin
			exp_mem[idx_q[IW-1:0]] <= e_c;
		end
		exp_rd_q <= exp_mem[idx_q[IW-1:0]];
	end

endmodule

### hdl/rsta_check.sv
// rsta_check: port-level checks of the activation unit's result channel
// bound to row_softmax_tanh_activation, depends on nothing else
module rsta_check (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] activation,
	input logic        row_end
);

	// a stalled result beat stays
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(activation) && $stable(row_end))
		else $error("result payload changed while stalled");

	// saturation keeps the most negative code out
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> activation != 16'h8000)
		else $error("activation outside saturation range");

	// only softmax beats can be mid-row, and probabilities are never negative
	a_prob_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !row_end |-> !activation[15])
		else $error("negative softmax probability");

endmodule

bind row_softmax_tanh_activation rsta_check u_rsta_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.activation (result_ch.activation),
	.row_end    (result_ch.row_end)
);
